// File: design/wcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcc_pkg
// shared types, codes and helper functions of the window crossing counter
// ----------------------------------------------------------------------------
package wcc_pkg;

    localparam int COORD_W    = 16;
    localparam int WIDE_W     = COORD_W + 1;
    localparam int TOTAL_W    = 24;
    localparam int EVENT_W    = 4;
    localparam int KIND_W     = 2;
    localparam int EDGE_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 56;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // request kinds
    localparam logic [KIND_W-1:0] KIND_OBSERVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

    // result events
    localparam logic [EVENT_W-1:0] EV_IGNORED   = 4'd0;
    localparam logic [EVENT_W-1:0] EV_ENTER_IN  = 4'd1;
    localparam logic [EVENT_W-1:0] EV_ENTER_OUT = 4'd2;
    localparam logic [EVENT_W-1:0] EV_COUNT_IN  = 4'd3;
    localparam logic [EVENT_W-1:0] EV_COUNT_OUT = 4'd4;
    localparam logic [EVENT_W-1:0] EV_LEFT      = 4'd5;
    localparam logic [EVENT_W-1:0] EV_FULL      = 4'd6;
    localparam logic [EVENT_W-1:0] EV_BEGUN     = 4'd7;
    localparam logic [EVENT_W-1:0] EV_ENDED     = 4'd8;

    // window edges
    localparam logic [EDGE_W-1:0] EDGE_BOTTOM = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_TOP    = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_LEFT   = 2'd2;
    localparam logic [EDGE_W-1:0] EDGE_RIGHT  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LEFT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_TOP    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SPAN_X = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SPAN_Y = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_EDGE       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_EDGE      = 3'd5;

    // entry side stored with each tracked id
    localparam logic SIDE_IN  = 1'b0;
    localparam logic SIDE_OUT = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CENTER = 6'b000010,
        ST_DIST   = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_DONE   = 6'b100000
    } wcc_state_t;

    function automatic logic [WIDE_W-1:0] abs_diff(input logic [WIDE_W-1:0] a,
                                                   input logic [WIDE_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [WIDE_W-1:0] edge_dist(input logic [EDGE_W-1:0] edge_sel,
                                                    input logic [WIDE_W-1:0] cx,
                                                    input logic [WIDE_W-1:0] cy,
                                                    input logic [WIDE_W-1:0] left,
                                                    input logic [WIDE_W-1:0] top,
                                                    input logic [WIDE_W-1:0] right,
                                                    input logic [WIDE_W-1:0] bottom);
        case (edge_sel)
            EDGE_BOTTOM: edge_dist = abs_diff(cy, bottom);
            EDGE_TOP:    edge_dist = abs_diff(cy, top);
            EDGE_LEFT:   edge_dist = abs_diff(cx, left);
            default:     edge_dist = abs_diff(cx, right);
        endcase
    endfunction

endpackage
`default_nettype wire

// File: design/window_crossing_counter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_crossing_counter_top
// counts tracked objects crossing a rectangular window between its in and out edges
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser carries the kind (observation,
// begin, end), s_tdata the object id and its bounding box. Each request gives
// exactly one result on the m_ channel: the event code and both totals.
// The user must set the window and the in and out edges through cfg_we/
// cfg_addr/cfg_wdata only while the block is idle; the block does not enforce this.
// An observation made while counting passes the center, distance, scan and
// decide states before its result is ready, and no new request is taken
// until that result has gone to the output register: the id table is a
// memory read one slot per cycle, and one comparator walks all slots
// looking for the id and the lowest free slot. Begin, end, an unused kind
// and an observation while not counting go straight to the done state.
// s_tready is high only while no request is in work; a request may be taken
// while the previous result still waits in the output register. When the
// receiver stalls, the finished result waits in the block until the output
// register frees up.
// Reset (aresetn low, synchronous) stops counting, clears totals and all
// table valid bits, empties the output and restores the default window.
// ----------------------------------------------------------------------------
module window_crossing_counter_top
    import wcc_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int ID_BITS     = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [COORD_W-1:0]     cfg_wdata,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // object_id, box_x, box_y, box_w, box_h
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    // kind
    input  wire logic [KIND_W-1:0]      s_tuser,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // event_res, in_total, out_total, zero pad
    output logic [OUT_DATA_W-1:0]       m_tdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_DEPTH);

    wcc_state_t state_reg, state_next;

    logic [COORD_W-1:0] win_left_reg, win_top_reg, span_x_reg, span_y_reg;
    logic [EDGE_W-1:0]  in_edge_reg, out_edge_reg;

    logic                   active_reg, active_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TOTAL_W-1:0]     cnt_in_reg, cnt_in_next;
    logic [TOTAL_W-1:0]     cnt_out_reg, cnt_out_next;

    logic [ID_BITS-1:0] id_reg;
    logic [COORD_W-1:0] bx_reg, by_reg, bw_reg, bh_reg;
    logic [WIDE_W-1:0]  cx_reg, cy_reg, right_reg, bottom_reg;
    logic [WIDE_W-1:0]  din_reg, dout_reg;
    logic               inside_reg;

    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic               pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]   pipe_idx_reg;
    logic               pipe_used_reg;
    logic [ID_BITS:0]   rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;

    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               hit_side_reg, hit_side_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    logic [EVENT_W-1:0] ev_reg, ev_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ID_BITS:0]   mem_wdata;
    logic [ID_BITS:0]   slot_mem [TABLE_DEPTH];

    logic               s_accept;
    logic               out_free;
    logic               near_in;
    logic [WIDE_W-1:0]  left_w, top_w;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign near_in  = din_reg < dout_reg;
    assign left_w   = WIDE_W'(win_left_reg);
    assign top_w    = WIDE_W'(win_top_reg);
    assign rd_addr  = scan_cnt_reg[IDX_W-1:0];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg <= '0;
            win_top_reg  <= '0;
            span_x_reg   <= '0;
            span_y_reg   <= '0;
            in_edge_reg  <= EDGE_BOTTOM;
            out_edge_reg <= EDGE_TOP;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_WINDOW_LEFT:   win_left_reg <= cfg_wdata;
                REG_WINDOW_TOP:    win_top_reg  <= cfg_wdata;
                REG_WINDOW_SPAN_X: span_x_reg   <= cfg_wdata;
                REG_WINDOW_SPAN_Y: span_y_reg   <= cfg_wdata;
                REG_IN_EDGE:       in_edge_reg  <= cfg_wdata[EDGE_W-1:0];
                REG_OUT_EDGE:      out_edge_reg <= cfg_wdata[EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    // id table: entry side above the id
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        active_next     = active_reg;
        valid_next      = valid_reg;
        cnt_in_next     = cnt_in_reg;
        cnt_out_next    = cnt_out_reg;
        scan_cnt_next   = scan_cnt_reg;
        pipe_vld_next   = 1'b0;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_side_next   = hit_side_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ev_next         = ev_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx_reg;
        mem_wdata       = {near_in ? SIDE_IN : SIDE_OUT, id_reg};

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    ev_next    = EV_IGNORED;
                    state_next = ST_DONE;
                    case (s_tuser)
                        KIND_BEGIN: begin
                            if (!active_reg) begin
                                cnt_in_next  = '0;
                                cnt_out_next = '0;
                                active_next  = 1'b1;
                                ev_next      = EV_BEGUN;
                            end
                        end
                        KIND_END: begin
                            if (active_reg) begin
                                active_next = 1'b0;
                                valid_next  = '0;
                                ev_next     = EV_ENDED;
                            end
                        end
                        KIND_OBSERVE: begin
                            if (active_reg) begin
                                state_next = ST_CENTER;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CENTER: begin
                state_next = ST_DIST;
            end
            ST_DIST: begin
                scan_cnt_next   = '0;
                hit_found_next  = 1'b0;
                free_found_next = 1'b0;
                state_next      = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_cnt_reg != SCAN_END) begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                end else if (!pipe_vld_reg) begin
                    state_next = ST_DECIDE;
                end
                // shared compare against the slot read last cycle
                if (pipe_vld_reg) begin
                    if (pipe_used_reg) begin
                        if (!hit_found_reg && rd_data_reg[ID_BITS-1:0] == id_reg) begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = pipe_idx_reg;
                            hit_side_next  = rd_data_reg[ID_BITS];
                        end
                    end else if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = pipe_idx_reg;
                    end
                end
            end
            ST_DECIDE: begin
                state_next = ST_DONE;
                ev_next    = EV_IGNORED;
                if (!hit_found_reg) begin
                    if (inside_reg) begin
                        if (!free_found_reg) begin
                            ev_next = EV_FULL;
                        end else begin
                            mem_we                   = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            ev_next = near_in ? EV_ENTER_IN : EV_ENTER_OUT;
                        end
                    end
                end else if (!inside_reg) begin
                    ev_next                 = EV_LEFT;
                    valid_next[hit_idx_reg] = 1'b0;
                    if (near_in && hit_side_reg == SIDE_OUT) begin
                        ev_next = EV_COUNT_IN;
                        if (cnt_in_reg != TOTAL_MAX) begin
                            cnt_in_next = cnt_in_reg + 1'b1;
                        end
                    end else if (!near_in && hit_side_reg == SIDE_IN) begin
                        ev_next = EV_COUNT_OUT;
                        if (cnt_out_reg != TOTAL_MAX) begin
                            cnt_out_next = cnt_out_reg + 1'b1;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_DATA_W'({cnt_out_reg, cnt_in_reg, ev_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= 1'b0;
            valid_reg    <= '0;
            cnt_in_reg   <= '0;
            cnt_out_reg  <= '0;
            pipe_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            valid_reg    <= valid_next;
            cnt_in_reg   <= cnt_in_next;
            cnt_out_reg  <= cnt_out_next;
            pipe_vld_reg <= pipe_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        scan_cnt_reg   <= scan_cnt_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_side_reg   <= hit_side_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        ev_reg         <= ev_next;
        m_tdata_reg    <= m_tdata_next;
        pipe_idx_reg   <= rd_addr;
        pipe_used_reg  <= valid_reg[rd_addr];
        if (s_accept) begin
            id_reg <= ID_BITS'(s_tdata[15:0]);
            bx_reg <= s_tdata[31:16];
            by_reg <= s_tdata[47:32];
            bw_reg <= s_tdata[63:48];
            bh_reg <= s_tdata[79:64];
        end
        if (state_reg == ST_CENTER) begin
            cx_reg     <= WIDE_W'(bx_reg) + WIDE_W'(bw_reg[COORD_W-1:1]);
            cy_reg     <= WIDE_W'(by_reg) + WIDE_W'(bh_reg[COORD_W-1:1]);
            right_reg  <= WIDE_W'(win_left_reg) + WIDE_W'(span_x_reg);
            bottom_reg <= WIDE_W'(win_top_reg) + WIDE_W'(span_y_reg);
        end
        if (state_reg == ST_DIST) begin
            din_reg    <= edge_dist(in_edge_reg, cx_reg, cy_reg,
                                    left_w, top_w, right_reg, bottom_reg);
            dout_reg   <= edge_dist(out_edge_reg, cx_reg, cy_reg,
                                    left_w, top_w, right_reg, bottom_reg);
            inside_reg <= (cx_reg >= left_w) && (cx_reg <= right_reg) &&
                          (cy_reg >= top_w) && (cy_reg <= bottom_reg);
        end
    end

endmodule
`default_nettype wire

// File: tb/tb_window_crossing_counter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_window_crossing_counter_top
// self-checking bench for the window crossing counter
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the window, the id table and the
// totals, predicts the event and totals of every accepted request and checks
// each result in order. A directed start walks through the begin/end rules,
// entries, exits, ties and the window corners. It is followed by phases of
// tracked objects that enter near an edge and leave past one, mixed with
// noise. The window is reprogrammed between phases, the extreme settings
// among them. One phase fills the id table, one runs with no idling and one
// holds the result side off for a long stretch while requests keep coming.
// ----------------------------------------------------------------------------
module tb_window_crossing_counter_top;
    import wcc_pkg::*;

    localparam int SLOTS = 64;
    localparam int MAX_CENTER = 98302;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [EVENT_W-1:0] ev;
        logic [TOTAL_W-1:0] in_total;
        logic [TOTAL_W-1:0] out_total;
    } crossing_t;

    class crossing_scoreboard;
        bit [COORD_W-1:0] win_left, win_top, span_x, span_y;
        bit [EDGE_W-1:0]  in_sel, out_sel;
        bit               active;
        bit               slot_used [SLOTS];
        bit [15:0]        slot_id [SLOTS];
        bit               slot_side [SLOTS];
        bit [TOTAL_W-1:0] total_in, total_out;
        crossing_t        pending_results [$];
        int               errors;

        function new();
            out_sel = EDGE_TOP;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function void set_reg(bit [CFG_ADDR_W-1:0] idx, bit [COORD_W-1:0] v);
            case (idx)
                REG_WINDOW_LEFT:   win_left = v;
                REG_WINDOW_TOP:    win_top = v;
                REG_WINDOW_SPAN_X: span_x = v;
                REG_WINDOW_SPAN_Y: span_y = v;
                REG_IN_EDGE:       in_sel = v[1:0];
                REG_OUT_EDGE:      out_sel = v[1:0];
                default: ;
            endcase
        endfunction

        function bit [WIDE_W-1:0] gap_to(bit [EDGE_W-1:0] sel, bit [WIDE_W-1:0] cx,
                                         bit [WIDE_W-1:0] cy);
            bit [WIDE_W-1:0] a, b;
            case (sel)
                EDGE_BOTTOM: begin
                    a = cy;
                    b = WIDE_W'(win_top) + WIDE_W'(span_y);
                end
                EDGE_TOP: begin
                    a = cy;
                    b = WIDE_W'(win_top);
                end
                EDGE_LEFT: begin
                    a = cx;
                    b = WIDE_W'(win_left);
                end
                default: begin
                    a = cx;
                    b = WIDE_W'(win_left) + WIDE_W'(span_x);
                end
            endcase
            return (a >= b) ? a - b : b - a;
        endfunction

        function bit [EVENT_W-1:0] track_object(bit [IN_DATA_W-1:0] d);
            bit [15:0]       id;
            bit [WIDE_W-1:0] cx, cy, right, bottom;
            bit              near_in, in_win;
            int              hit, free;
            id = d[15:0];
            cx = WIDE_W'(d[31:16]) + WIDE_W'(d[63:49]);
            cy = WIDE_W'(d[47:32]) + WIDE_W'(d[79:65]);
            right = WIDE_W'(win_left) + WIDE_W'(span_x);
            bottom = WIDE_W'(win_top) + WIDE_W'(span_y);
            near_in = gap_to(in_sel, cx, cy) < gap_to(out_sel, cx, cy);
            in_win = cx >= win_left && cx <= right && cy >= win_top && cy <= bottom;
            hit = -1;
            free = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i]) begin
                    if (hit < 0 && slot_id[i] == id) hit = i;
                end else if (free < 0) begin
                    free = i;
                end
            end
            if (hit < 0) begin
                if (!in_win) return EV_IGNORED;
                if (free < 0) return EV_FULL;
                slot_used[free] = 1'b1;
                slot_id[free] = id;
                slot_side[free] = near_in ? SIDE_IN : SIDE_OUT;
                return near_in ? EV_ENTER_IN : EV_ENTER_OUT;
            end
            if (in_win) return EV_IGNORED;
            slot_used[hit] = 1'b0;
            if (near_in && slot_side[hit] == SIDE_OUT) begin
                if (total_in != TOTAL_MAX) total_in++;
                return EV_COUNT_IN;
            end
            if (!near_in && slot_side[hit] == SIDE_IN) begin
                if (total_out != TOTAL_MAX) total_out++;
                return EV_COUNT_OUT;
            end
            return EV_LEFT;
        endfunction

        function void note_request(bit [KIND_W-1:0] kind, bit [IN_DATA_W-1:0] d);
            crossing_t r;
            r.ev = EV_IGNORED;
            case (kind)
                KIND_BEGIN: begin
                    if (!active) begin
                        total_in = '0;
                        total_out = '0;
                        active = 1'b1;
                        r.ev = EV_BEGUN;
                    end
                end
                KIND_END: begin
                    if (active) begin
                        active = 1'b0;
                        foreach (slot_used[i]) slot_used[i] = 1'b0;
                        r.ev = EV_ENDED;
                    end
                end
                KIND_OBSERVE: begin
                    if (active) r.ev = track_object(d);
                end
                default: ;
            endcase
            r.in_total = total_in;
            r.out_total = total_out;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void check_result(bit [OUT_DATA_W-1:0] d);
            crossing_t got, want;
            got.ev = d[3:0];
            got.in_total = d[27:4];
            got.out_total = d[51:28];
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result with no request pending: event %0d in %0d out %0d",
                             got.ev, got.in_total, got.out_total);
                return;
            end
            want = pending_results.pop_front();
            if (got != want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: event %0d/%0d in %0d/%0d out %0d/%0d (exp/act)",
                             want.ev, got.ev, want.in_total, got.in_total,
                             want.out_total, got.out_total);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [COORD_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    crossing_scoreboard sb = new();
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;
    int        cfg_left, cfg_top, cfg_sx, cfg_sy;
    bit [1:0]  cfg_in, cfg_out;
    bit [15:0] live_ids [$];

    window_crossing_counter_top #(
        .TABLE_DEPTH(SLOTS),
        .ID_BITS    (16)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int pick(int lo, int hi);
        return (hi <= lo) ? lo : lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clamp_center(int v);
        return (v < 0) ? 0 : (v > MAX_CENTER) ? MAX_CENTER : v;
    endfunction

    // box of random size whose center lands on (cx, cy)
    function automatic bit [IN_DATA_W-1:0] box_around(bit [15:0] id, int cx, int cy);
        int        tx, ty, hx, hy;
        bit [15:0] x, y, w, h;
        tx = clamp_center(cx);
        ty = clamp_center(cy);
        hx = pick(tx > 65535 ? tx - 65535 : 0, tx < 32767 ? tx : 32767);
        hy = pick(ty > 65535 ? ty - 65535 : 0, ty < 32767 ? ty : 32767);
        w = 16'(2 * hx + int'($urandom_range(1)));
        h = 16'(2 * hy + int'($urandom_range(1)));
        x = 16'(tx - hx);
        y = 16'(ty - hy);
        return {h, w, y, x, id};
    endfunction

    // center just inside the window near an edge, or just past it
    task automatic choose_center(input bit into, input bit [1:0] sel,
                                 output int cx, output int cy);
        int l, t, r, b, d;
        l = cfg_left;
        t = cfg_top;
        r = cfg_left + cfg_sx;
        b = cfg_top + cfg_sy;
        cx = pick(l, r);
        cy = pick(t, b);
        if (into) begin
            case (sel)
                EDGE_BOTTOM: cy = b - pick(0, cfg_sy < 40 ? cfg_sy : 40);
                EDGE_TOP:    cy = t + pick(0, cfg_sy < 40 ? cfg_sy : 40);
                EDGE_LEFT:   cx = l + pick(0, cfg_sx < 40 ? cfg_sx : 40);
                default:     cx = r - pick(0, cfg_sx < 40 ? cfg_sx : 40);
            endcase
        end else begin
            d = pick(1, 300);
            case (sel)
                EDGE_BOTTOM: cy = b + d;
                EDGE_TOP:    cy = t - d;
                EDGE_LEFT:   cx = l - d;
                default:     cx = r + d;
            endcase
        end
    endtask

    task automatic write_reg(bit [CFG_ADDR_W-1:0] idx, bit [COORD_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic program_window(int l, int t, int sx, int sy, int ie, int oe);
        cfg_left = l;
        cfg_top = t;
        cfg_sx = sx;
        cfg_sy = sy;
        cfg_in = 2'(ie);
        cfg_out = 2'(oe);
        write_reg(REG_WINDOW_LEFT, 16'(l));
        write_reg(REG_WINDOW_TOP, 16'(t));
        write_reg(REG_WINDOW_SPAN_X, 16'(sx));
        write_reg(REG_WINDOW_SPAN_Y, 16'(sy));
        // upper bits of the edge registers are don't care
        write_reg(REG_IN_EDGE, 16'({$urandom_range(16383), 2'(ie)}));
        write_reg(REG_OUT_EDGE, 16'({$urandom_range(16383), 2'(oe)}));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_request(bit [KIND_W-1:0] kind, bit [IN_DATA_W-1:0] data);
        int gap;
        if (!calm && $urandom_range(99) < 9) begin
            gap = ($urandom_range(3) == 0) ? pick(4, 80) : pick(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, data);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic run_phase(int goal, int live_cap, int new_pct);
        int          tries, roll, k, cx, cy;
        bit [15:0]   id;
        bit [1:0]    sel;
        bit [KIND_W-1:0] kind;
        tries = 0;
        send_request(KIND_BEGIN, IN_DATA_W'({$urandom, $urandom, $urandom}));
        while (tries < goal) begin
            tries++;
            roll = $urandom_range(99);
            sel = ($urandom_range(4) == 0) ? 2'($urandom_range(3))
                                           : ($urandom_range(1) ? cfg_in : cfg_out);
            if (roll < 8) begin
                kind = 2'($urandom_range(3));
                // keep the table filling in the crowded phase
                if (live_cap > SLOTS && kind == KIND_END) kind = KIND_BEGIN;
                send_request(kind, IN_DATA_W'({$urandom, $urandom, $urandom}));
            end else if (live_ids.size() == 0 ||
                         (roll < 8 + new_pct && live_ids.size() < live_cap)) begin
                id = 16'($urandom);
                if (live_ids.size() > 0 && $urandom_range(15) == 0)
                    id = live_ids[$urandom_range(live_ids.size() - 1)];
                choose_center(1'b1, sel, cx, cy);
                send_request(KIND_OBSERVE, box_around(id, cx, cy));
                live_ids.insert(live_ids.size(), id);
            end else if (roll < 18 + new_pct) begin
                k = $urandom_range(live_ids.size() - 1);
                choose_center(1'b1, 2'($urandom_range(3)), cx, cy);
                send_request(KIND_OBSERVE, box_around(live_ids[k], cx, cy));
            end else begin
                k = $urandom_range(live_ids.size() - 1);
                id = live_ids[k];
                live_ids.delete(k);
                if ($urandom_range(9) == 0) begin
                    cx = pick(0, MAX_CENTER);
                    cy = pick(0, MAX_CENTER);
                end else begin
                    choose_center(1'b0, sel, cx, cy);
                end
                send_request(KIND_OBSERVE, box_around(id, cx, cy));
            end
        end
        if ($urandom_range(9) < 7) begin
            send_request(KIND_END, IN_DATA_W'({$urandom, $urandom, $urandom}));
            live_ids.delete();
        end
    endtask

    // result side: check, random stalls, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_req && hold_left == 0) begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: right edge 1100, bottom edge 800, in at top, out at bottom
        program_window(100, 200, 1000, 600, EDGE_TOP, EDGE_BOTTOM);
        send_request(KIND_OBSERVE, box_around(16'h0011, 500, 500));
        send_request(KIND_END, '0);
        send_request(KIND_UNUSED, '1);
        send_request(KIND_BEGIN, '0);
        send_request(KIND_BEGIN, '1);
        send_request(KIND_OBSERVE, box_around(16'h0001, 600, 210));
        send_request(KIND_OBSERVE, box_around(16'h0001, 600, 500));
        send_request(KIND_OBSERVE, box_around(16'h0001, 600, 900));
        send_request(KIND_OBSERVE, box_around(16'h0002, 600, 790));
        send_request(KIND_OBSERVE, box_around(16'h0002, 600, 150));
        send_request(KIND_OBSERVE, box_around(16'h0003, 300, 205));
        send_request(KIND_OBSERVE, box_around(16'h0003, 300, 100));
        send_request(KIND_OBSERVE, box_around(16'h0004, 50, 50));
        send_request(KIND_OBSERVE, box_around(16'h0005, 600, 500));
        send_request(KIND_OBSERVE, '1);
        send_request(KIND_OBSERVE, '0);
        send_request(KIND_OBSERVE, box_around(16'h0007, 100, 200));
        send_request(KIND_OBSERVE, box_around(16'h0008, 1100, 800));
        send_request(KIND_OBSERVE, box_around(16'hFFFF, 600, 400));
        send_request(KIND_OBSERVE, box_around(16'hFFFF, 1200, 500));
        send_request(KIND_END, '0);
        send_request(KIND_OBSERVE, box_around(16'h0009, 600, 500));
        send_request(KIND_END, '1);
        wait_drained();

        for (int p = 0; p < 12; p++) begin
            case (p)
                0: program_window(65535, 65535, 65535, 65535, EDGE_RIGHT, EDGE_LEFT);
                1: program_window(0, 0, 0, 0, EDGE_BOTTOM, EDGE_BOTTOM);
                2: program_window(1000, 1000, 3000, 3000, $urandom_range(3),
                                  $urandom_range(3));
                default: program_window(pick(0, 40000), pick(0, 40000), pick(0, 20000),
                                        pick(0, 20000), $urandom_range(3),
                                        $urandom_range(3));
            endcase
            calm = (p == 5);
            if (p == 3) hold_req = 1'b1;
            if (p == 2) run_phase(260, 100, 70);
            else run_phase(125, 6, 40);
            wait_drained();
        end
        calm = 1'b0;

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
